/* src/refcounted_port_table_assert.svh */
// assertion macros for the refcounted port table
// no dependencies; included by the top level
`ifndef REFCOUNTED_PORT_TABLE_ASSERT_SVH
`define REFCOUNTED_PORT_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled during reset
`define RPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpt assertion failed");
// next-cycle implication, disabled during reset
`define RPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpt assertion failed");
`else
`define RPT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RPT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* src/rpt_pkg.sv */
// shared types and constants for the refcounted port table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rpt_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int PORT_W            = 16;
    localparam int TIME_W            = 32;
    localparam int COUNT_W           = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    // request codes
    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_SEARCH = 2'd3
    } t_action;

    // response codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

endpackage

`default_nettype wire

/* src/rpt_ifs.sv */
// valid/ready channel interfaces for requests and responses
// depends on rpt_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rpt_req_if;
    logic                        valid;
    logic                        ready;
    rpt_pkg::t_action            action;
    logic [rpt_pkg::PORT_W-1:0]  port;
    logic [rpt_pkg::TIME_W-1:0]  now;

    modport source (output valid, action, port, now, input ready);
    modport sink   (input valid, action, port, now, output ready);
endinterface

interface rpt_rsp_if;
    logic                        valid;
    logic                        ready;
    rpt_pkg::t_status            status;
    logic [rpt_pkg::COUNT_W-1:0] use_count;
    logic [rpt_pkg::TIME_W-1:0]  created_at;

    modport source (output valid, status, use_count, created_at, input ready);
    modport sink   (input valid, status, use_count, created_at, output ready);
endinterface

`default_nettype wire

/* src/rpt_prio_enc.sv */
// lowest-index priority encoder used for slot match and free-slot search
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rpt_prio_enc #(
    parameter int ENTRIES = 16
) (
    input  wire logic [ENTRIES-1:0]         i_vec,
    output logic                            o_found,
    output logic [$clog2(ENTRIES)-1:0]      o_index
);

    localparam int IDX_W = $clog2(ENTRIES);

    // any request set
    assign o_found = |i_vec;

    // scan from the top so the lowest set bit wins
    always_comb begin
        o_index = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (i_vec[i]) begin
                o_index = IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

/* src/refcounted_port_table.sv */
// Refcounted port table: add/delete/clear/search against all slots compared in parallel.
// Items pass the input register, then the result register once that is free or draining.
// Throughput: one item per cycle while o_rsp accepts responses; the single
//   compare-and-update pass sets the pace.
// Reset (synchronous, active low): all slots free, input and output registers empty.
// Depends on rpt_pkg, rpt_ifs, rpt_prio_enc and refcounted_port_table_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

module refcounted_port_table #(
    parameter int TABLE_ENTRIES = rpt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rpt_req_if.sink     i_req,
    rpt_rsp_if.source   o_rsp
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    // input register
    logic                        r_in_valid;
    rpt_pkg::t_action            r_in_action;
    logic [rpt_pkg::PORT_W-1:0]  r_in_port;
    logic [rpt_pkg::TIME_W-1:0]  r_in_now;

    // table storage
    logic [TABLE_ENTRIES-1:0]    r_slot_valid;
    logic [TABLE_ENTRIES-1:0]    n_slot_valid;
    logic [rpt_pkg::PORT_W-1:0]  r_slot_port  [TABLE_ENTRIES];
    logic [rpt_pkg::TIME_W-1:0]  r_slot_time  [TABLE_ENTRIES];
    logic [rpt_pkg::COUNT_W-1:0] r_slot_count [TABLE_ENTRIES];

    // result register
    logic                        r_out_valid;
    rpt_pkg::t_status            r_out_status;
    rpt_pkg::t_status            n_out_status;
    logic [rpt_pkg::COUNT_W-1:0] r_out_count;
    logic [rpt_pkg::COUNT_W-1:0] n_out_count;
    logic [rpt_pkg::TIME_W-1:0]  r_out_time;
    logic [rpt_pkg::TIME_W-1:0]  n_out_time;

    // lookup and update controls
    logic                        w_fire;
    logic [TABLE_ENTRIES-1:0]    w_hit_vec;
    logic                        w_hit;
    logic [IDX_W-1:0]            w_hit_idx;
    logic                        w_free;
    logic [IDX_W-1:0]            w_free_idx;
    logic [rpt_pkg::COUNT_W-1:0] w_sel_count;
    logic [rpt_pkg::TIME_W-1:0]  w_sel_time;
    logic [rpt_pkg::COUNT_W-1:0] w_inc_count;
    logic                        w_wr_en;
    logic                        w_wr_new;
    logic [IDX_W-1:0]            w_wr_idx;

    // handshake: process when the result register is free or being drained
    assign w_fire      = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_action <= i_req.action;
            r_in_port   <= i_req.port;
            r_in_now    <= i_req.now;
        end
    end

    // parallel port compare against every valid slot
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_hit_vec[i] = r_slot_valid[i] && (r_slot_port[i] == r_in_port);
        end
    end

    rpt_prio_enc #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_match_enc (
        .i_vec   (w_hit_vec),
        .o_found (w_hit),
        .o_index (w_hit_idx)
    );

    rpt_prio_enc #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_free_enc (
        .i_vec   (~r_slot_valid),
        .o_found (w_free),
        .o_index (w_free_idx)
    );

    // matched record and its saturating increment
    assign w_sel_count = r_slot_count[w_hit_idx];
    assign w_sel_time  = r_slot_time[w_hit_idx];
    assign w_inc_count = (w_sel_count == rpt_pkg::COUNT_MAX) ? w_sel_count
                                                             : w_sel_count + 1'b1;

    // request decode: next table state and response
    always_comb begin
        n_slot_valid = r_slot_valid;
        n_out_status = rpt_pkg::ST_OK;
        n_out_count  = '0;
        n_out_time   = '0;
        w_wr_en      = 1'b0;
        w_wr_new     = 1'b0;
        w_wr_idx     = w_hit_idx;
        case (r_in_action)
            rpt_pkg::ACT_ADD: begin
                if (w_hit) begin
                    w_wr_en     = 1'b1;
                    n_out_count = w_inc_count;
                    n_out_time  = w_sel_time;
                end else if (w_free) begin
                    w_wr_en                  = 1'b1;
                    w_wr_new                 = 1'b1;
                    w_wr_idx                 = w_free_idx;
                    n_slot_valid[w_free_idx] = 1'b1;
                    n_out_count              = rpt_pkg::COUNT_ONE;
                    n_out_time               = r_in_now;
                end else begin
                    n_out_status = rpt_pkg::ST_FULL;
                end
            end
            rpt_pkg::ACT_DELETE: begin
                if (w_hit) begin
                    n_slot_valid[w_hit_idx] = 1'b0;
                end else begin
                    n_out_status = rpt_pkg::ST_NOT_FOUND;
                end
            end
            rpt_pkg::ACT_CLEAR: begin
                n_slot_valid = '0;
            end
            rpt_pkg::ACT_SEARCH: begin
                if (w_hit) begin
                    n_out_count = w_sel_count;
                    n_out_time  = w_sel_time;
                end else begin
                    n_out_status = rpt_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                n_out_status = rpt_pkg::ST_OK;
            end
        endcase
    end

    // slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
        end else if (w_fire) begin
            r_slot_valid <= n_slot_valid;
        end
    end

    // slot payload, one write port
    always_ff @(posedge i_clk) begin
        if (w_fire && w_wr_en) begin
            r_slot_count[w_wr_idx] <= n_out_count;
            if (w_wr_new) begin
                r_slot_port[w_wr_idx] <= r_in_port;
                r_slot_time[w_wr_idx] <= r_in_now;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_status <= n_out_status;
            r_out_count  <= n_out_count;
            r_out_time   <= n_out_time;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.use_count  = r_out_count;
    assign o_rsp.created_at = r_out_time;

    // checks
`include "refcounted_port_table_assert.svh"

    `RPT_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, w_fire && r_in_action == rpt_pkg::ACT_CLEAR, r_slot_valid == '0)
    `RPT_ASSERT_NEXT(a_add_marks_valid, i_clk, i_rst_n, w_fire && r_in_action == rpt_pkg::ACT_ADD && (w_hit || w_free), r_slot_valid[$past(w_wr_idx)])
    `RPT_ASSERT_NOW(a_miss_zero_fields, i_clk, i_rst_n, r_out_valid && r_out_status != rpt_pkg::ST_OK, r_out_count == '0 && r_out_time == '0)

endmodule

`default_nettype wire
